@@ rtl/pidpi_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pidpi_pkg;

    // Default timing limits in microseconds.
    localparam int MAX_INTERVAL_US_DEF     = 500000;
    localparam int DEFAULT_INTERVAL_US_DEF = 10000;

    // Field and datapath widths.
    localparam int DATA_W  = 32;  // Q16.16 values and gains
    localparam int ERR_W   = 33;  // setpoint minus measurement
    localparam int DT_W    = 24;  // sample interval in microseconds
    localparam int IDX_W   = 3;   // register index
    localparam int OPA_W   = 42;  // signed wide multiplier operand
    localparam int MAGA_W  = 41;  // its magnitude
    localparam int MAGB_W  = 32;  // magnitude of the serial multiplier operand
    localparam int MHI_W   = 42;  // upper half of the product accumulator
    localparam int PMAG_W  = 73;  // product magnitude
    localparam int PROD_W  = 74;  // signed product
    localparam int NUM_W   = 62;  // signed dividend
    localparam int DQ_W    = 61;  // dividend magnitude and quotient
    localparam int TERM_W  = 42;  // saturated P, I and D terms
    localparam int INCR_W  = 39;  // integral increment
    localparam int SUM_W   = 45;  // sum of held output and terms
    localparam int CNT_W   = 6;

    // Index of the last sequencer step; the steps are load, iterations, write back.
    localparam int MUL_LAST = 33;
    localparam int DIV_LAST = 62;

    // Scale between seconds and microseconds.
    localparam int ONE_MILLION = 1000000;

    // Register indexes of the configuration port.
    localparam logic [IDX_W-1:0] CFG_GAIN_P      = 3'd0;
    localparam logic [IDX_W-1:0] CFG_GAIN_I      = 3'd1;
    localparam logic [IDX_W-1:0] CFG_GAIN_D      = 3'd2;
    localparam logic [IDX_W-1:0] CFG_OUT_UPPER   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_OUT_LOWER   = 3'd4;
    localparam logic [IDX_W-1:0] CFG_INTEG_UPPER = 3'd5;
    localparam logic [IDX_W-1:0] CFG_INTEG_LOWER = 3'd6;

    // Update modes.
    localparam logic KIND_POSITIONAL  = 1'b0;
    localparam logic KIND_INCREMENTAL = 1'b1;

    // Saturation bounds of one term.
    localparam logic signed [PROD_W-1:0] TERM_MAX = PROD_W'(64'd1 << 40);
    localparam logic signed [PROD_W-1:0] TERM_MIN = -TERM_MAX;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INC_MUL,
        ST_INC_DIV,
        ST_P_MUL,
        ST_I_MUL,
        ST_D_MUL,
        ST_D_SCALE,
        ST_D_DIV,
        ST_SUM,
        ST_DONE
    } t_state;

    // Clamp a wide value into a limit pair that may be given in either order.
    function automatic logic signed [DATA_W-1:0] clamp_pair(
        input logic signed [SUM_W-1:0]  v,
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [DATA_W-1:0] lo;
        logic signed [DATA_W-1:0] hi;
        logic signed [DATA_W-1:0] res;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (v > SUM_W'(hi)) begin
            res = hi;
        end else if (v < SUM_W'(lo)) begin
            res = lo;
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

    // Saturate a product or quotient to plus or minus 2^40.
    function automatic logic signed [TERM_W-1:0] term_sat(
        input logic signed [PROD_W-1:0] v
    );
        logic signed [TERM_W-1:0] res;
        if (v > TERM_MAX) begin
            res = TERM_MAX[TERM_W-1:0];
        end else if (v < TERM_MIN) begin
            res = TERM_MIN[TERM_W-1:0];
        end else begin
            res = v[TERM_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/pid_positional_incremental_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// PID controller in Q16.16 fixed point with a positional and an incremental law.
// Each request carries setpoint, measurement and either a millisecond tick or a
// direct interval, and yields one clamped output. All products and quotients run
// through one bit-serial shift-and-add multiplier and one restoring divider that
// retire one bit per cycle. A request passes through five multiplications and
// two divisions, then a sum step and a clamp step. A new request is taken as
// soon as the sequencer is idle, even while the previous result still waits in
// the output register. Configuration writes take effect at once and must be
// made while idle.
module pid_positional_incremental_unit #(
    parameter int MAX_INTERVAL_US     = pidpi_pkg::MAX_INTERVAL_US_DEF,
    parameter int DEFAULT_INTERVAL_US = pidpi_pkg::DEFAULT_INTERVAL_US_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // Configuration port
    input  wire logic                                  i_cfg_we,
    input  wire logic [pidpi_pkg::IDX_W-1:0]           i_cfg_index,
    input  wire logic [pidpi_pkg::DATA_W-1:0]          i_cfg_data,
    // Input channel
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire logic                                  i_kind,
    input  wire logic                                  i_time_source,
    input  wire logic signed [pidpi_pkg::DATA_W-1:0]   i_setpoint,
    input  wire logic signed [pidpi_pkg::DATA_W-1:0]   i_measurement,
    input  wire logic [pidpi_pkg::DATA_W-1:0]          i_time_ms,
    input  wire logic [pidpi_pkg::DT_W-1:0]            i_interval_us,
    // Output channel
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic signed [pidpi_pkg::DATA_W-1:0]        o_control_out
);
    import pidpi_pkg::*;

    localparam int MAX_MS = MAX_INTERVAL_US / 1000;
    localparam logic [DT_W-1:0] DT_MAX = DT_W'(MAX_INTERVAL_US);
    localparam logic [DT_W-1:0] DT_DEF = DT_W'(DEFAULT_INTERVAL_US);

    // Configuration registers.
    logic signed [DATA_W-1:0] r_gain_p, r_gain_i, r_gain_d;
    logic signed [DATA_W-1:0] r_out_upper, r_out_lower, r_integ_upper, r_integ_lower;

    // Controller state.
    logic signed [DATA_W-1:0] r_integ;
    logic signed [ERR_W-1:0]  r_last_err;
    logic signed [ERR_W-1:0]  r_older_err;
    logic signed [DATA_W-1:0] r_last_meas;
    logic signed [DATA_W-1:0] r_held;
    logic [DATA_W-1:0]        r_last_tick;
    logic                     r_primed;

    // Current request.
    logic                     r_kind;
    logic signed [ERR_W-1:0]  r_err;
    logic signed [DATA_W-1:0] r_meas;
    logic [DT_W-1:0]          r_dt;

    // Intermediate results.
    logic signed [INCR_W-1:0] r_incr;
    logic signed [TERM_W-1:0] r_p, r_i, r_t, r_d;
    logic signed [NUM_W-1:0]  r_num;
    logic signed [SUM_W-1:0]  r_sum;

    // Serial multiplier.
    logic [MAGA_W-1:0] r_ma;
    logic [MHI_W-1:0]  r_mhi;
    logic [MAGB_W-1:0] r_mlo;
    logic              r_mneg;

    // Serial divider.
    logic [DQ_W-1:0]   r_dq;
    logic [DT_W-1:0]   r_rem;
    logic [DT_W-1:0]   r_dd;
    logic              r_dneg;

    // Sequencer and output register.
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_out_valid;
    logic signed [DATA_W-1:0] r_out;

    logic in_fire;
    logic out_free;

    // Interval and error of an arriving request.
    logic [DATA_W-1:0]        c_dms;
    logic [DT_W-1:0]          c_ms_us;
    logic [DT_W-1:0]          c_raw;
    logic                     c_raw_big;
    logic [DT_W-1:0]          c_dt_def;
    logic [DT_W-1:0]          c_dt;
    logic signed [ERR_W-1:0]  c_err;

    // Operand selection.
    logic signed [ERR_W:0]    c_xp;
    logic signed [ERR_W+1:0]  c_xd;
    logic signed [OPA_W-1:0]  c_opa;
    logic signed [ERR_W-1:0]  c_opb;
    logic signed [OPA_W-1:0]  c_nega;
    logic signed [ERR_W-1:0]  c_negb;
    logic [MAGA_W-1:0]        c_maga;
    logic [MAGB_W-1:0]        c_magb;

    // Arithmetic unit results.
    logic [MHI_W-1:0]         c_msum;
    logic signed [PROD_W-1:0] c_pmag;
    logic signed [PROD_W-1:0] c_prod;
    logic signed [PROD_W-1:0] c_prod_q;
    logic [DT_W:0]            c_rsh;
    logic                     c_rge;
    logic [DT_W:0]            c_rsub;
    logic signed [NUM_W-1:0]  c_q;
    logic signed [NUM_W-1:0]  c_numneg;
    logic signed [SUM_W-1:0]  c_integ_sum;
    logic signed [DATA_W-1:0] c_res;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // Interval from the tick or the direct field, defaulted and capped.
    always_comb begin
        c_dms     = i_time_ms - r_last_tick;
        c_ms_us   = c_dms[DT_W-1:0] * DT_W'(1000);
        c_raw_big = 1'b0;
        if (i_time_source) begin
            c_raw = i_interval_us;
        end else if (r_last_tick == '0) begin
            c_raw = DT_DEF;
        end else begin
            c_raw     = c_ms_us;
            c_raw_big = (c_dms > DATA_W'(MAX_MS));
        end
        c_dt_def = (c_raw == '0) ? DT_DEF : c_raw;
        c_dt     = (c_raw_big || c_dt_def > DT_MAX) ? DT_MAX : c_dt_def;
        c_err    = ERR_W'(i_setpoint) - ERR_W'(i_measurement);
    end

    // Operands of the serial multiplier for each step.
    always_comb begin
        c_xp = (r_kind == KIND_INCREMENTAL) ? ((ERR_W+1)'(r_err) - (ERR_W+1)'(r_last_err))
                                            : (ERR_W+1)'(r_err);
        c_xd = (r_kind == KIND_INCREMENTAL)
             ? ((ERR_W+2)'(r_err) - ((ERR_W+2)'(r_last_err) <<< 1) + (ERR_W+2)'(r_older_err))
             : ((ERR_W+2)'(r_meas) - (ERR_W+2)'(r_last_meas));
        unique case (r_state)
            ST_INC_MUL: begin
                c_opa = OPA_W'(r_err);
                c_opb = ERR_W'(signed'({1'b0, r_dt}));
            end
            ST_P_MUL: begin
                c_opa = OPA_W'(c_xp);
                c_opb = ERR_W'(r_gain_p);
            end
            ST_I_MUL: begin
                c_opa = (r_kind == KIND_INCREMENTAL) ? OPA_W'(r_incr) : OPA_W'(r_integ);
                c_opb = ERR_W'(r_gain_i);
            end
            ST_D_MUL: begin
                c_opa = OPA_W'(c_xd);
                c_opb = ERR_W'(r_gain_d);
            end
            ST_D_SCALE: begin
                c_opa = OPA_W'(r_t);
                c_opb = ERR_W'(ONE_MILLION);
            end
            default: begin
                c_opa = '0;
                c_opb = '0;
            end
        endcase
        c_nega = -c_opa;
        c_negb = -c_opb;
        c_maga = c_opa[OPA_W-1] ? c_nega[MAGA_W-1:0] : c_opa[MAGA_W-1:0];
        c_magb = c_opb[ERR_W-1] ? c_negb[MAGB_W-1:0] : c_opb[MAGB_W-1:0];
    end

    // Multiplier step, signed product and its Q16.16 rescale.
    always_comb begin
        c_msum   = r_mhi + (r_mlo[0] ? MHI_W'(r_ma) : MHI_W'(0));
        c_pmag   = signed'({1'b0, r_mhi[MAGA_W-1:0], r_mlo});
        c_prod   = r_mneg ? -c_pmag : c_pmag;
        c_prod_q = c_prod >>> 16;
    end

    // Divider step and floored signed quotient.
    always_comb begin
        c_rsh    = {r_rem, r_dq[DQ_W-1]};
        c_rge    = (c_rsh >= {1'b0, r_dd});
        c_rsub   = c_rsh - {1'b0, r_dd};
        c_q      = r_dneg ? (~signed'({1'b0, r_dq}) + NUM_W'(r_rem == '0))
                          : signed'({1'b0, r_dq});
        c_numneg = -r_num;
    end

    assign c_integ_sum = SUM_W'(r_integ) + SUM_W'(r_incr);
    assign c_res       = clamp_pair(r_sum, r_out_upper, r_out_lower);

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and input ready.
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = ST_INC_MUL;
                    n_cnt   = '0;
                end
            end
            ST_INC_MUL, ST_P_MUL, ST_I_MUL, ST_D_MUL, ST_D_SCALE: begin
                if (r_cnt == CNT_W'(MUL_LAST)) begin
                    n_cnt = '0;
                    unique case (r_state)
                        ST_INC_MUL: n_state = ST_INC_DIV;
                        ST_P_MUL:   n_state = ST_I_MUL;
                        ST_I_MUL:   n_state = ST_D_MUL;
                        ST_D_MUL:   n_state = ST_D_SCALE;
                        default:    n_state = ST_D_DIV;
                    endcase
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_INC_DIV, ST_D_DIV: begin
                if (r_cnt == CNT_W'(DIV_LAST)) begin
                    n_cnt   = '0;
                    n_state = (r_state == ST_INC_DIV) ? ST_P_MUL : ST_SUM;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_SUM: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state: configuration, controller memory and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p      <= '0;
            r_gain_i      <= '0;
            r_gain_d      <= '0;
            r_out_upper   <= DATA_W'(32'h7FFF_FFFF);
            r_out_lower   <= DATA_W'(32'h8000_0000);
            r_integ_upper <= DATA_W'(32'h7FFF_FFFF);
            r_integ_lower <= DATA_W'(32'h8000_0000);
            r_integ       <= '0;
            r_last_err    <= '0;
            r_older_err   <= '0;
            r_last_meas   <= '0;
            r_held        <= '0;
            r_last_tick   <= '0;
            r_primed      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            // Register writes; a limit write also clamps the value it bounds.
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_GAIN_P: r_gain_p <= i_cfg_data;
                    CFG_GAIN_I: r_gain_i <= i_cfg_data;
                    CFG_GAIN_D: r_gain_d <= i_cfg_data;
                    CFG_OUT_UPPER: begin
                        r_out_upper <= i_cfg_data;
                        r_held <= clamp_pair(SUM_W'(r_held), i_cfg_data, r_out_lower);
                    end
                    CFG_OUT_LOWER: begin
                        r_out_lower <= i_cfg_data;
                        r_held <= clamp_pair(SUM_W'(r_held), r_out_upper, i_cfg_data);
                    end
                    CFG_INTEG_UPPER: begin
                        r_integ_upper <= i_cfg_data;
                        r_integ <= clamp_pair(SUM_W'(r_integ), i_cfg_data, r_integ_lower);
                    end
                    CFG_INTEG_LOWER: begin
                        r_integ_lower <= i_cfg_data;
                        r_integ <= clamp_pair(SUM_W'(r_integ), r_integ_upper, i_cfg_data);
                    end
                    default: begin
                    end
                endcase
            end

            // Tick tracking and first-sample history on acceptance.
            if (in_fire) begin
                if (!i_time_source && r_last_tick != '0) begin
                    r_last_tick <= i_time_ms;
                end else if (!i_time_source) begin
                    r_last_tick <= i_time_ms;
                end
                if (!r_primed) begin
                    r_last_meas <= i_measurement;
                    r_last_err  <= c_err;
                    r_older_err <= c_err;
                    r_primed    <= 1'b1;
                end
            end

            // Positional law folds the increment into the clamped integral.
            if (r_state == ST_P_MUL && r_cnt == '0 && r_kind == KIND_POSITIONAL) begin
                r_integ <= clamp_pair(c_integ_sum, r_integ_upper, r_integ_lower);
            end

            // Retire the request into the output register and the history.
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
                r_held      <= c_res;
                r_older_err <= r_last_err;
                r_last_err  <= r_err;
                r_last_meas <= r_meas;
            end
        end
    end

    // Datapath registers of the request and the serial units.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_kind <= i_kind;
            r_err  <= c_err;
            r_meas <= i_measurement;
            r_dt   <= c_dt;
        end

        unique case (r_state)
            ST_INC_MUL, ST_P_MUL, ST_I_MUL, ST_D_MUL, ST_D_SCALE: begin
                if (r_cnt == '0) begin
                    r_ma   <= c_maga;
                    r_mlo  <= c_magb;
                    r_mhi  <= '0;
                    r_mneg <= c_opa[OPA_W-1] ^ c_opb[ERR_W-1];
                end else if (r_cnt == CNT_W'(MUL_LAST)) begin
                    unique case (r_state)
                        ST_INC_MUL: r_num <= c_prod[NUM_W-1:0];
                        ST_P_MUL:   r_p   <= term_sat(c_prod_q);
                        ST_I_MUL:   r_i   <= term_sat(c_prod_q);
                        ST_D_MUL:   r_t   <= term_sat(c_prod_q);
                        default:    r_num <= c_prod[NUM_W-1:0];
                    endcase
                end else begin
                    r_mhi <= {1'b0, c_msum[MHI_W-1:1]};
                    r_mlo <= {c_msum[0], r_mlo[MAGB_W-1:1]};
                end
            end
            ST_INC_DIV, ST_D_DIV: begin
                if (r_cnt == '0) begin
                    r_dq   <= r_num[NUM_W-1] ? c_numneg[DQ_W-1:0] : r_num[DQ_W-1:0];
                    r_dneg <= r_num[NUM_W-1];
                    r_rem  <= '0;
                    r_dd   <= (r_state == ST_INC_DIV) ? DT_W'(ONE_MILLION) : r_dt;
                end else if (r_cnt == CNT_W'(DIV_LAST)) begin
                    if (r_state == ST_INC_DIV) begin
                        r_incr <= c_q[INCR_W-1:0];
                    end else begin
                        r_d <= term_sat(PROD_W'(c_q));
                    end
                end else begin
                    r_rem <= c_rge ? c_rsub[DT_W-1:0] : c_rsh[DT_W-1:0];
                    r_dq  <= {r_dq[DQ_W-2:0], c_rge};
                end
            end
            ST_SUM: begin
                if (r_kind == KIND_INCREMENTAL) begin
                    r_sum <= SUM_W'(r_held) + SUM_W'(r_p) + SUM_W'(r_i) + SUM_W'(r_d);
                end else begin
                    r_sum <= SUM_W'(r_p) + SUM_W'(r_i) - SUM_W'(r_d);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    r_out <= c_res;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid   = r_out_valid;
    assign o_control_out = r_out;

    // A retired request shows up in the output register on the next cycle.
    a_retire_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && out_free) |=> (o_out_valid && o_control_out == r_held))
        else $error("retired result not presented");

    // A waiting result is the value held for the incremental law.
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_control_out == r_held))
        else $error("output and held value disagree");

    // The integral stays inside its sorted limit pair.
    a_integ_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_integ <= r_integ_upper || r_integ <= r_integ_lower) &&
         (r_integ >= r_integ_upper || r_integ >= r_integ_lower)))
        else $error("integral outside its limits");

endmodule

`default_nettype wire

@@ verif/pid_positional_incremental_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels and the register port of the PID unit, keeps its own
// Q16.16 controller state, and compares every output with the predicted one.
module pid_positional_incremental_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pidpi_pkg::IDX_W-1:0]         i_cfg_index,
    input  logic [pidpi_pkg::DATA_W-1:0]        i_cfg_data,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic                                i_kind,
    input  logic                                i_time_source,
    input  logic signed [pidpi_pkg::DATA_W-1:0] i_setpoint,
    input  logic signed [pidpi_pkg::DATA_W-1:0] i_measurement,
    input  logic [pidpi_pkg::DATA_W-1:0]        i_time_ms,
    input  logic [pidpi_pkg::DT_W-1:0]          i_interval_us,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [pidpi_pkg::DATA_W-1:0] i_control_out,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import pidpi_pkg::*;

    localparam longint TERM_LIMIT   = longint'(1) << 40;
    localparam longint MAX_DT_US    = 500000;
    localparam longint DFLT_DT_US   = 10000;
    localparam longint US_PER_SEC   = 1000000;

    // Controller settings and state as the unit should hold them.
    longint kp, ki, kd;
    longint out_hi_reg, out_lo_reg, acc_hi_reg, acc_lo_reg;
    longint integral, prev_err, prev2_err, prev_meas, held_out;
    logic [31:0] prev_tick;
    logic        warmed_up;

    logic signed [DATA_W-1:0] expected_outputs[$];

    function automatic longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if (n % d < 0) begin
            q = q - 1;
        end
        return q;
    endfunction

    function automatic longint limit(longint v, longint lo, longint hi);
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic longint limit_pair(longint v, longint a, longint b);
        return a < b ? limit(v, a, b) : limit(v, b, a);
    endfunction

    // Gain times Q16.16 value, rounded toward minus infinity.
    function automatic longint q16_mul(longint g, longint x);
        longint xh, xl;
        xh = floor_div(x, 65536);
        xl = x - xh * 65536;
        return g * xh + floor_div(g * xl, 65536);
    endfunction

    function automatic longint rate_term(longint g, longint diff, longint dt);
        longint t;
        t = limit(q16_mul(g, diff), -TERM_LIMIT, TERM_LIMIT);
        return limit(floor_div(t * US_PER_SEC, dt), -TERM_LIMIT, TERM_LIMIT);
    endfunction

    // One control step: settle the interval, run the selected law, update state.
    function automatic logic signed [DATA_W-1:0] pid_output(
        logic kind, logic tsrc, longint sp, longint meas,
        logic [31:0] tick, logic [DT_W-1:0] ivl
    );
        longint dt, err, incr, p, i, d, res;
        logic [31:0] dms;
        if (tsrc) begin
            dt = longint'(ivl);
        end else if (prev_tick == 32'd0) begin
            prev_tick = tick;
            dt = DFLT_DT_US;
        end else begin
            dms = tick - prev_tick;
            prev_tick = tick;
            dt = longint'(dms) * 1000;
        end
        if (dt == 0) dt = DFLT_DT_US;
        if (dt > MAX_DT_US) dt = MAX_DT_US;

        err = sp - meas;
        if (!warmed_up) begin
            prev_meas = meas;
            prev_err  = err;
            prev2_err = err;
            warmed_up = 1'b1;
        end
        incr = floor_div(err * dt, US_PER_SEC);

        if (kind == KIND_POSITIONAL) begin
            integral = limit_pair(integral + incr, acc_hi_reg, acc_lo_reg);
            p = limit(q16_mul(kp, err), -TERM_LIMIT, TERM_LIMIT);
            i = limit(q16_mul(ki, integral), -TERM_LIMIT, TERM_LIMIT);
            d = rate_term(kd, meas - prev_meas, dt);
            res = limit_pair(p + i - d, out_hi_reg, out_lo_reg);
        end else begin
            p = limit(q16_mul(kp, err - prev_err), -TERM_LIMIT, TERM_LIMIT);
            i = limit(q16_mul(ki, incr), -TERM_LIMIT, TERM_LIMIT);
            d = rate_term(kd, err - 2 * prev_err + prev2_err, dt);
            res = limit_pair(held_out + p + i + d, out_hi_reg, out_lo_reg);
        end
        held_out  = res;
        prev2_err = prev_err;
        prev_err  = err;
        prev_meas = meas;
        return res[DATA_W-1:0];
    endfunction

    assign o_pending = expected_outputs.size();

    always @(posedge i_clk) begin
        logic signed [DATA_W-1:0] want;
        longint cfg;
        if (!i_rst_n) begin
            kp = 0; ki = 0; kd = 0;
            out_hi_reg = 64'sd2147483647;  out_lo_reg = -64'sd2147483648;
            acc_hi_reg = 64'sd2147483647;  acc_lo_reg = -64'sd2147483648;
            integral = 0; prev_err = 0; prev2_err = 0; prev_meas = 0; held_out = 0;
            prev_tick = 32'd0;
            warmed_up = 1'b0;
            expected_outputs.delete();
            o_fail_count = 0;
        end else begin
            // Register writes; a limit write pulls the matching state inside.
            if (i_cfg_we) begin
                cfg = longint'($signed(i_cfg_data));
                case (i_cfg_index)
                    CFG_GAIN_P: kp = cfg;
                    CFG_GAIN_I: ki = cfg;
                    CFG_GAIN_D: kd = cfg;
                    CFG_OUT_UPPER: begin
                        out_hi_reg = cfg;
                        held_out = limit_pair(held_out, out_hi_reg, out_lo_reg);
                    end
                    CFG_OUT_LOWER: begin
                        out_lo_reg = cfg;
                        held_out = limit_pair(held_out, out_hi_reg, out_lo_reg);
                    end
                    CFG_INTEG_UPPER: begin
                        acc_hi_reg = cfg;
                        integral = limit_pair(integral, acc_hi_reg, acc_lo_reg);
                    end
                    CFG_INTEG_LOWER: begin
                        acc_lo_reg = cfg;
                        integral = limit_pair(integral, acc_hi_reg, acc_lo_reg);
                    end
                    default: ;
                endcase
            end
            // Accepted result against the oldest prediction.
            if (i_out_valid && i_out_ready) begin
                if (expected_outputs.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    if (o_fail_count <= 10)
                        $display("ERROR: unexpected output %0d", i_control_out);
                end else begin
                    want = expected_outputs.pop_front();
                    if (want !== i_control_out) begin
                        o_fail_count = o_fail_count + 1;
                        if (o_fail_count <= 10)
                            $display("ERROR: control_out expected %0d got %0d",
                                     want, i_control_out);
                    end
                end
            end
            // Accepted request produces one predicted output.
            if (i_in_valid && i_in_ready) begin
                expected_outputs.push_back(pid_output(i_kind, i_time_source,
                    longint'(i_setpoint), longint'(i_measurement),
                    i_time_ms, i_interval_us));
            end
        end
    end

endmodule

@@ verif/pid_positional_incremental_unit_tb.sv @@
`timescale 1ns / 1ps

module pid_positional_incremental_unit_tb;
    import pidpi_pkg::*;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [IDX_W-1:0]         i_cfg_index = '0;
    logic [DATA_W-1:0]        i_cfg_data = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic                     i_kind = 1'b0;
    logic                     i_time_source = 1'b0;
    logic signed [DATA_W-1:0] i_setpoint = '0;
    logic signed [DATA_W-1:0] i_measurement = '0;
    logic [DATA_W-1:0]        i_time_ms = '0;
    logic [DT_W-1:0]          i_interval_us = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic signed [DATA_W-1:0] o_control_out;

    int fail_count;
    int pending_outputs;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int recv_hold_cycles = 0;
    logic [31:0] tick_now = 32'd1;

    pid_positional_incremental_unit dut (.*);

    pid_positional_incremental_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready),
        .i_kind(i_kind), .i_time_source(i_time_source),
        .i_setpoint(i_setpoint), .i_measurement(i_measurement),
        .i_time_ms(i_time_ms), .i_interval_us(i_interval_us),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_control_out(o_control_out),
        .o_fail_count(fail_count), .o_pending(pending_outputs)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (recv_hold_cycles > 0) begin
            i_out_ready <= 1'b0;
            recv_hold_cycles <= recv_hold_cycles - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

    // Offer one request and hold it until the unit takes it.
    task automatic send_sample(logic kind, logic tsrc, logic [31:0] sp,
                               logic [31:0] meas, logic [31:0] tms, logic [23:0] ivl);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_kind        <= kind;
        i_time_source <= tsrc;
        i_setpoint    <= sp;
        i_measurement <= meas;
        i_time_ms     <= tms;
        i_interval_us <= ivl;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Wait until every output has come back, then let the unit settle.
    task automatic drain();
        while (pending_outputs != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    function automatic logic [31:0] random_gain();
        if ($urandom_range(9) == 0) return $urandom;
        return $signed($urandom) >>> $urandom_range(8, 20);
    endfunction

    function automatic logic [31:0] random_value();
        if ($urandom_range(9) == 0) return $urandom;
        return $signed($urandom) >>> $urandom_range(4, 14);
    endfunction

    task automatic random_config();
        logic [31:0] a, b;
        write_reg(CFG_GAIN_P, random_gain());
        write_reg(CFG_GAIN_I, random_gain());
        write_reg(CFG_GAIN_D, random_gain());
        a = $urandom_range(1) ? $urandom : 32'h7FFF_FFFF;
        b = $urandom_range(1) ? $urandom : 32'h8000_0000;
        write_reg(CFG_OUT_UPPER, a);
        write_reg(CFG_OUT_LOWER, b);
        a = $signed($urandom) >>> $urandom_range(0, 6);
        b = $signed($urandom) >>> $urandom_range(0, 6);
        write_reg(CFG_INTEG_UPPER, a);
        write_reg(CFG_INTEG_LOWER, b);
    endtask

    // Mostly a steadily advancing tick and plausible values; now and then noise.
    task automatic random_sample();
        logic [23:0] ivl;
        if ($urandom_range(19) == 0) tick_now = $urandom;
        else tick_now = tick_now + $urandom_range(0, 40);
        ivl = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 600000));
        send_sample(1'($urandom_range(1)), 1'($urandom_range(1)), random_value(),
                    random_value(), tick_now, ivl);
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed samples: timestamps, intervals and value extremes.
        write_reg(CFG_GAIN_P, 32'h0001_0000);
        write_reg(CFG_GAIN_I, 32'h0000_8000);
        write_reg(CFG_GAIN_D, 32'h0000_0100);
        send_sample(KIND_POSITIONAL, 1'b0, 32'h0002_0000, 32'h0001_0000, 32'd0, 24'd0);
        send_sample(KIND_POSITIONAL, 1'b0, 32'h0002_0000, 32'h0000_0000, 32'd100, 24'd0);
        send_sample(KIND_POSITIONAL, 1'b0, 32'h0002_0000, 32'hFFFF_0000, 32'd100, 24'd0);
        send_sample(KIND_POSITIONAL, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd700, 24'd0);
        send_sample(KIND_INCREMENTAL, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFF0, 24'd0);
        send_sample(KIND_INCREMENTAL, 1'b0, 32'h0000_1000, 32'h0000_0000, 32'd5, 24'd0);
        send_sample(KIND_INCREMENTAL, 1'b1, 32'h0001_0000, 32'h0000_0000, 32'd0, 24'd0);
        send_sample(KIND_INCREMENTAL, 1'b1, 32'h0003_0000, 32'h0000_0000, 32'd0, 24'hFF_FFFF);
        send_sample(KIND_POSITIONAL, 1'b1, 32'h0000_0000, 32'h7FFF_FFFF, 32'd0, 24'd1);
        send_sample(KIND_POSITIONAL, 1'b1, 32'h8000_0000, 32'h8000_0000, 32'd0, 24'd500001);
        drain();

        // Extreme gains, swapped limits, and limit writes that clip the state.
        write_reg(CFG_GAIN_P, 32'h7FFF_FFFF);
        write_reg(CFG_GAIN_I, 32'h8000_0000);
        write_reg(CFG_GAIN_D, 32'h8000_0000);
        write_reg(CFG_OUT_UPPER, 32'hFFF0_0000);
        write_reg(CFG_OUT_LOWER, 32'h0010_0000);
        write_reg(CFG_INTEG_UPPER, 32'h0000_1000);
        write_reg(CFG_INTEG_LOWER, 32'hFFFF_F000);
        for (int n = 0; n < 8; n++) random_sample();
        send_sample(KIND_INCREMENTAL, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 24'd1);
        send_sample(KIND_POSITIONAL, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 24'd1);
        drain();
        write_reg(CFG_OUT_UPPER, 32'h8000_0000);
        write_reg(CFG_OUT_LOWER, 32'h7FFF_FFFF);
        write_reg(CFG_INTEG_UPPER, 32'h8000_0000);
        write_reg(CFG_INTEG_LOWER, 32'h7FFF_FFFF);

        // Random phases with changing idle patterns and settings.
        for (int n = 0; n < 730; n++) begin
            if (n == 0) begin
                send_idle_pct = 24; recv_idle_pct = 62;
            end else if (n == 250) begin
                send_idle_pct = 62; recv_idle_pct = 24;
            end else if (n == 500) begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            if (n == 60) recv_hold_cycles = 3000;
            if (n % 120 == 119) begin
                drain();
                random_config();
            end
            random_sample();
        end

        for (int c = 0; c < 200000 && pending_outputs != 0; c++) @(negedge i_clk);
        repeat (320) @(negedge i_clk);
        if (fail_count == 0 && pending_outputs == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
